>>> rtl/core/vslt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vslt_pkg
// Shared types and constants of the visitor slot lifecycle table.
// ----------------------------------------------------------------------------
package vslt_pkg;

	// table size limits and field widths
	localparam int SLOTS_DEF = 8;
	localparam int SLOTS_MAX = 64;
	localparam int IDX_W     = 8;
	localparam int SLOT_W    = 6;
	localparam int CNT_W     = 7;
	localparam int TOT_W     = 32;
	localparam int ST_W      = 3;

	// lifecycle state of one slot
	typedef enum logic [ST_W-1:0] {
		SLOT_EMPTY    = 3'd0,
		SLOT_DETECTED = 3'd1,
		SLOT_WELCOMED = 3'd2,
		SLOT_SERVED   = 3'd3,
		SLOT_DECIDED  = 3'd4,
		SLOT_EXPIRED  = 3'd5
	} slot_state_t;

	// request codes
	typedef enum logic [1:0] {
		REQ_DETECT = 2'd0,
		REQ_SERVE  = 2'd1,
		REQ_DECIDE = 2'd2,
		REQ_EXPIRE = 2'd3
	} req_t;

	// controller states
	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_SCAN,
		FSM_SCAN_END,
		FSM_LOOKUP,
		FSM_COMMIT
	} fsm_state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic capture;
		logic scan_rd;
		logic lookup_rd;
		logic commit;
	} ctrl_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic scan_last;
	} dp_status_t;

endpackage
`default_nettype wire

>>> rtl/core/visitor_slot_lifecycle_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// visitor_slot_lifecycle_table
// Slot table with detect, serve, decide and expire requests.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Exactly one result
// follows, shown for a single cycle while done is high; the receiver cannot
// stall it, so it must take the beat in that cycle. A detect request scans
// the slot memory one entry per cycle through its read port, then passes
// a scan-end state and a commit state. Serve, decide and expire read one
// entry in a lookup state and then commit. busy falls in the cycle that
// done is shown, so a new request may be taken then. Counts and totals
// are kept in registers and hold between results.
module visitor_slot_lifecycle_table
	import vslt_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [1:0]        req_type,
	input  wire logic [IDX_W-1:0]  slot_index,
	input  wire logic              join_choice,
	output logic                   done,
	output logic                   status,
	output logic [SLOT_W-1:0]      granted_slot,
	output logic [CNT_W-1:0]       active_count,
	output logic [CNT_W-1:0]       decided_count,
	output logic [TOT_W-1:0]       total_received,
	output logic [TOT_W-1:0]       total_joined,
	output logic [TOT_W-1:0]       total_left,
	output logic [TOT_W-1:0]       total_expired
);

	ctrl_cmd_t  cmd;
	dp_status_t stat;

	// sequencer
	vslt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req_type),
		.stat     (stat),
		.cmd      (cmd),
		.busy     (busy)
	);

	// table and counters
	vslt_datapath #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.req_type       (req_type),
		.slot_index     (slot_index),
		.join_choice    (join_choice),
		.stat           (stat),
		.done           (done),
		.status         (status),
		.granted_slot   (granted_slot),
		.active_count   (active_count),
		.decided_count  (decided_count),
		.total_received (total_received),
		.total_joined   (total_joined),
		.total_left     (total_left),
		.total_expired  (total_expired)
	);

endmodule
`default_nettype wire

>>> rtl/core/vslt_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vslt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module vslt_ram #(
	parameter int WIDTH = 3,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

>>> rtl/core/vslt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vslt_ctrl
// Controller: sequences capture, slot scan or lookup, and commit.
// ----------------------------------------------------------------------------
module vslt_ctrl
	import vslt_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire logic [1:0] req_type,
	input  wire dp_status_t stat,
	output ctrl_cmd_t       cmd,
	output logic            busy
);

	fsm_state_t state_q, state_nxt;
	logic       accept;

	assign accept = start && (state_q == FSM_IDLE);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			FSM_IDLE: begin
				if (accept) begin
					state_nxt = (req_t'(req_type) == REQ_DETECT) ? FSM_SCAN : FSM_LOOKUP;
				end
			end
			FSM_SCAN: begin
				if (stat.scan_last) begin
					state_nxt = FSM_SCAN_END;
				end
			end
			FSM_SCAN_END: state_nxt = FSM_COMMIT;
			FSM_LOOKUP:   state_nxt = FSM_COMMIT;
			FSM_COMMIT:   state_nxt = FSM_IDLE;
			default:      state_nxt = FSM_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd           = '0;
		busy          = 1'b1;
		case (state_q)
			FSM_IDLE: begin
				busy        = 1'b0;
				cmd.capture = start;
			end
			FSM_SCAN:     cmd.scan_rd   = 1'b1;
			FSM_SCAN_END: cmd           = '0;
			FSM_LOOKUP:   cmd.lookup_rd = 1'b1;
			FSM_COMMIT:   cmd.commit    = 1'b1;
			default:      cmd           = '0;
		endcase
	end

endmodule
`default_nettype wire

>>> rtl/core/vslt_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vslt_datapath
// Slot state memory, free-slot scan, lifecycle update, counts and totals.
// ----------------------------------------------------------------------------
module vslt_datapath
	import vslt_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF,
	localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ctrl_cmd_t         cmd,
	input  wire logic [1:0]        req_type,
	input  wire logic [IDX_W-1:0]  slot_index,
	input  wire logic              join_choice,
	output dp_status_t             stat,
	output logic                   done,
	output logic                   status,
	output logic [SLOT_W-1:0]      granted_slot,
	output logic [CNT_W-1:0]       active_count,
	output logic [CNT_W-1:0]       decided_count,
	output logic [TOT_W-1:0]       total_received,
	output logic [TOT_W-1:0]       total_joined,
	output logic [TOT_W-1:0]       total_left,
	output logic [TOT_W-1:0]       total_expired
);

	// captured request
	req_t            req_q;
	logic [AW-1:0]   idx_q;
	logic            bad_q;
	logic            join_q;

	// scan bookkeeping
	logic [AW-1:0]   scan_q;
	logic            rvld_s1;
	logic [AW-1:0]   raddr_s1;
	logic            fe_q, ff_q, ff_dec_q;
	logic [AW-1:0]   fe_idx_q, ff_idx_q;

	// slot memory and per-entry written flags
	logic [SLOTS-1:0] vld_q;
	logic [ST_W-1:0]  rdata;
	logic [AW-1:0]    raddr;
	slot_state_t      scan_st, look_st;

	// commit results
	logic            ok;
	logic [AW-1:0]   wr_idx;
	slot_state_t     wr_st;
	logic            act_inc, act_dec, dec_inc, dec_dec;

	// registered outputs and running counts
	logic              done_q, status_q;
	logic [SLOT_W-1:0] granted_q;
	logic [CNT_W-1:0]  act_q, dec_q;
	logic [TOT_W-1:0]  rcv_q, join_tot_q, left_tot_q, exp_q;

	assign raddr          = cmd.lookup_rd ? idx_q : scan_q;
	assign stat.scan_last = (scan_q == AW'(SLOTS - 1));

	vslt_ram #(
		.WIDTH (ST_W),
		.DEPTH (SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (cmd.commit && ok),
		.waddr (wr_idx),
		.wdata (wr_st),
		.raddr (raddr),
		.rdata (rdata)
	);

	// unwritten entries read as empty
	assign scan_st = vld_q[raddr_s1] ? slot_state_t'(rdata) : SLOT_EMPTY;
	assign look_st = vld_q[idx_q]    ? slot_state_t'(rdata) : SLOT_EMPTY;

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q  <= req_t'(req_type);
			idx_q  <= slot_index[AW-1:0];
			bad_q  <= (slot_index >= IDX_W'(SLOTS));
			join_q <= join_choice;
		end
	end

	// scan address counter and read pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q  <= '0;
			rvld_s1 <= 1'b0;
		end else begin
			rvld_s1 <= cmd.scan_rd;
			if (cmd.capture) begin
				scan_q <= '0;
			end else if (cmd.scan_rd && !stat.scan_last) begin
				scan_q <= scan_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		raddr_s1 <= scan_q;
	end

	// lowest empty and lowest reusable slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fe_q <= 1'b0;
			ff_q <= 1'b0;
		end else if (cmd.capture) begin
			fe_q <= 1'b0;
			ff_q <= 1'b0;
		end else if (rvld_s1) begin
			if (scan_st == SLOT_EMPTY && !fe_q) begin
				fe_q <= 1'b1;
			end
			if (scan_st inside {SLOT_DECIDED, SLOT_EXPIRED} && !ff_q) begin
				ff_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rvld_s1) begin
			if (scan_st == SLOT_EMPTY && !fe_q) begin
				fe_idx_q <= raddr_s1;
			end
			if (scan_st inside {SLOT_DECIDED, SLOT_EXPIRED} && !ff_q) begin
				ff_idx_q <= raddr_s1;
				ff_dec_q <= (scan_st == SLOT_DECIDED);
			end
		end
	end

	// lifecycle transition
	always_comb begin
		ok      = 1'b0;
		wr_idx  = idx_q;
		wr_st   = SLOT_EMPTY;
		act_inc = 1'b0;
		act_dec = 1'b0;
		dec_inc = 1'b0;
		dec_dec = 1'b0;
		case (req_q)
			REQ_DETECT: begin
				ok      = fe_q || ff_q;
				wr_idx  = fe_q ? fe_idx_q : ff_idx_q;
				wr_st   = SLOT_WELCOMED;
				act_inc = 1'b1;
				dec_dec = !fe_q && ff_dec_q;
			end
			REQ_SERVE: begin
				ok    = !bad_q && (look_st == SLOT_WELCOMED);
				wr_st = SLOT_SERVED;
			end
			REQ_DECIDE: begin
				ok      = !bad_q && (look_st inside {SLOT_WELCOMED, SLOT_SERVED});
				wr_st   = SLOT_DECIDED;
				act_dec = 1'b1;
				dec_inc = 1'b1;
			end
			REQ_EXPIRE: begin
				ok      = !bad_q &&
				          (look_st inside {SLOT_DETECTED, SLOT_WELCOMED, SLOT_SERVED});
				wr_st   = SLOT_EXPIRED;
				act_dec = 1'b1;
			end
			default: ok = 1'b0;
		endcase
	end

	// written flags, counts, totals and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q      <= '0;
			act_q      <= '0;
			dec_q      <= '0;
			rcv_q      <= '0;
			join_tot_q <= '0;
			left_tot_q <= '0;
			exp_q      <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q <= cmd.commit;
			if (cmd.commit && ok) begin
				vld_q[wr_idx] <= 1'b1;
				if (act_inc) begin
					act_q <= act_q + CNT_W'(1);
				end else if (act_dec) begin
					act_q <= act_q - CNT_W'(1);
				end
				if (dec_inc) begin
					dec_q <= dec_q + CNT_W'(1);
				end else if (dec_dec) begin
					dec_q <= dec_q - CNT_W'(1);
				end
				case (req_q)
					REQ_DETECT: rcv_q <= rcv_q + TOT_W'(1);
					REQ_DECIDE: begin
						if (join_q) begin
							join_tot_q <= join_tot_q + TOT_W'(1);
						end else begin
							left_tot_q <= left_tot_q + TOT_W'(1);
						end
					end
					REQ_EXPIRE: exp_q <= exp_q + TOT_W'(1);
					default:    rcv_q <= rcv_q;
				endcase
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status_q  <= !ok;
			granted_q <= (ok && req_q == REQ_DETECT) ? SLOT_W'(wr_idx) : '0;
		end
	end

	assign done           = done_q;
	assign status         = status_q;
	assign granted_slot   = granted_q;
	assign active_count   = act_q;
	assign decided_count  = dec_q;
	assign total_received = rcv_q;
	assign total_joined   = join_tot_q;
	assign total_left     = left_tot_q;
	assign total_expired  = exp_q;

endmodule
`default_nettype wire

>>> sim/visitor_slot_lifecycle_table_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// visitor_slot_lifecycle_table_checker
// Watches the request and result channels of the slot table, keeps its own
// copy of the slot states and totals, and compares every result beat.
// ----------------------------------------------------------------------------
module visitor_slot_lifecycle_table_checker
	import vslt_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic              busy,
	input  wire logic [1:0]        req_type,
	input  wire logic [IDX_W-1:0]  slot_index,
	input  wire logic              join_choice,
	input  wire logic              done,
	input  wire logic              status,
	input  wire logic [SLOT_W-1:0] granted_slot,
	input  wire logic [CNT_W-1:0]  active_count,
	input  wire logic [CNT_W-1:0]  decided_count,
	input  wire logic [TOT_W-1:0]  total_received,
	input  wire logic [TOT_W-1:0]  total_joined,
	input  wire logic [TOT_W-1:0]  total_left,
	input  wire logic [TOT_W-1:0]  total_expired,
	output int                     fail_count,
	output int                     outstanding,
	output int                     results_checked,
	output int                     error_replies,
	output int                     full_replies
);

	// one expected result beat
	typedef struct {
		logic              status;
		logic [SLOT_W-1:0] granted;
		logic [CNT_W-1:0]  active;
		logic [CNT_W-1:0]  decided;
		logic [TOT_W-1:0]  received;
		logic [TOT_W-1:0]  joined;
		logic [TOT_W-1:0]  left_cnt;
		logic [TOT_W-1:0]  expired;
	} visit_result_t;

	// shadow of the slot table and event totals
	slot_state_t       slot_tab [SLOTS_MAX];
	logic [TOT_W-1:0]  received_sum;
	logic [TOT_W-1:0]  joined_sum;
	logic [TOT_W-1:0]  left_sum;
	logic [TOT_W-1:0]  expired_sum;

	visit_result_t     pending_results [$];
	visit_result_t     want;
	visit_result_t     fresh;
	int                mismatches;
	int                n_checked;
	int                n_errors;
	int                n_full;

	assign fail_count      = mismatches;
	assign results_checked = n_checked;
	assign error_replies   = n_errors;
	assign full_replies    = n_full;

	// apply one request to the shadow table and return the reply it earns
	function automatic visit_result_t advance_table(input req_t op,
			input logic [IDX_W-1:0] idx, input logic join_sel);
		visit_result_t r;
		int pick;
		r = '{default: '0};
		pick = -1;
		if (op == REQ_DETECT) begin
			// lowest empty slot first, then lowest decided or expired one
			for (int i = 0; i < SLOTS; i++)
				if (pick < 0 && slot_tab[i] == SLOT_EMPTY)
					pick = i;
			for (int i = 0; i < SLOTS; i++)
				if (pick < 0 && (slot_tab[i] == SLOT_DECIDED || slot_tab[i] == SLOT_EXPIRED))
					pick = i;
			if (pick < 0) begin
				r.status = 1'b1;
			end else begin
				slot_tab[pick] = SLOT_WELCOMED;
				received_sum++;
				r.granted = pick[SLOT_W-1:0];
			end
		end else if (idx >= SLOTS) begin
			r.status = 1'b1;
		end else begin
			case (op)
				REQ_SERVE: begin
					if (slot_tab[idx] == SLOT_WELCOMED)
						slot_tab[idx] = SLOT_SERVED;
					else
						r.status = 1'b1;
				end
				REQ_DECIDE: begin
					if (slot_tab[idx] == SLOT_WELCOMED || slot_tab[idx] == SLOT_SERVED) begin
						slot_tab[idx] = SLOT_DECIDED;
						if (join_sel)
							joined_sum++;
						else
							left_sum++;
					end else begin
						r.status = 1'b1;
					end
				end
				default: begin
					if (slot_tab[idx] inside {SLOT_DETECTED, SLOT_WELCOMED, SLOT_SERVED}) begin
						slot_tab[idx] = SLOT_EXPIRED;
						expired_sum++;
					end else begin
						r.status = 1'b1;
					end
				end
			endcase
		end
		// counts are taken after the move
		for (int i = 0; i < SLOTS; i++) begin
			if (slot_tab[i] inside {SLOT_DETECTED, SLOT_WELCOMED, SLOT_SERVED})
				r.active++;
			else if (slot_tab[i] == SLOT_DECIDED)
				r.decided++;
		end
		r.received = received_sum;
		r.joined   = joined_sum;
		r.left_cnt = left_sum;
		r.expired  = expired_sum;
		return r;
	endfunction

	task automatic check_field(input string what, input logic [TOT_W-1:0] exp_val,
			input logic [TOT_W-1:0] got_val);
		if (exp_val !== got_val) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d",
				$time, what, exp_val, got_val);
			mismatches++;
		end
	endtask

	initial begin
		mismatches = 0;
		n_checked  = 0;
		n_errors   = 0;
		n_full     = 0;
	end

	// track request beats and compare result beats
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (slot_tab[i])
				slot_tab[i] = SLOT_EMPTY;
			received_sum = '0;
			joined_sum   = '0;
			left_sum     = '0;
			expired_sum  = '0;
			pending_results.delete();
			outstanding <= 0;
		end else begin
			// result beat: compare with the oldest expectation
			if (done) begin
				if (pending_results.size() == 0) begin
					$display("%0t ns: result beat with nothing expected, status %0d slot %0d",
						$time, status, granted_slot);
					mismatches++;
				end else begin
					want = pending_results.pop_front();
					check_field("status", TOT_W'(want.status), TOT_W'(status));
					check_field("granted_slot", TOT_W'(want.granted), TOT_W'(granted_slot));
					check_field("active_count", TOT_W'(want.active), TOT_W'(active_count));
					check_field("decided_count", TOT_W'(want.decided),
						TOT_W'(decided_count));
					check_field("total_received", want.received, total_received);
					check_field("total_joined", want.joined, total_joined);
					check_field("total_left", want.left_cnt, total_left);
					check_field("total_expired", want.expired, total_expired);
					n_checked++;
				end
			end
			// request beat: predict its reply
			if (start && !busy) begin
				fresh = advance_table(req_t'(req_type), slot_index, join_choice);
				if (fresh.status) begin
					n_errors++;
					if (req_t'(req_type) == REQ_DETECT)
						n_full++;
				end
				pending_results.push_back(fresh);
			end
			outstanding <= pending_results.size();
		end
	end

endmodule

>>> sim/visitor_slot_lifecycle_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// visitor_slot_lifecycle_table_tb
// Drives detect, serve, decide and expire requests into the slot table.
// ----------------------------------------------------------------------------
// A directed opening walks one slot through its lifecycle, hits every error
// path and fills the table; then random requests, mostly aimed at valid
// slots, run in three pacing phases. The checker beside the block predicts
// and compares every result beat.
module visitor_slot_lifecycle_table_tb;
	import vslt_pkg::*;

	localparam int SLOTS      = SLOTS_DEF;
	localparam int PHASE_REQS = 317;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic [1:0]        req_type = REQ_DETECT;
	logic [IDX_W-1:0]  slot_index = '0;
	logic              join_choice = 1'b0;
	logic              done;
	logic              status;
	logic [SLOT_W-1:0] granted_slot;
	logic [CNT_W-1:0]  active_count;
	logic [CNT_W-1:0]  decided_count;
	logic [TOT_W-1:0]  total_received;
	logic [TOT_W-1:0]  total_joined;
	logic [TOT_W-1:0]  total_left;
	logic [TOT_W-1:0]  total_expired;

	int fail_count;
	int outstanding;
	int results_checked;
	int error_replies;
	int full_replies;
	int gap_pct = 0;
	int issued = 0;

	visitor_slot_lifecycle_table #(.SLOTS(SLOTS)) dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.req_type       (req_type),
		.slot_index     (slot_index),
		.join_choice    (join_choice),
		.done           (done),
		.status         (status),
		.granted_slot   (granted_slot),
		.active_count   (active_count),
		.decided_count  (decided_count),
		.total_received (total_received),
		.total_joined   (total_joined),
		.total_left     (total_left),
		.total_expired  (total_expired)
	);

	visitor_slot_lifecycle_table_checker #(.SLOTS(SLOTS)) u_chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.req_type        (req_type),
		.slot_index      (slot_index),
		.join_choice     (join_choice),
		.done            (done),
		.status          (status),
		.granted_slot    (granted_slot),
		.active_count    (active_count),
		.decided_count   (decided_count),
		.total_received  (total_received),
		.total_joined    (total_joined),
		.total_left      (total_left),
		.total_expired   (total_expired),
		.fail_count      (fail_count),
		.outstanding     (outstanding),
		.results_checked (results_checked),
		.error_replies   (error_replies),
		.full_replies    (full_replies)
	);

	// 100 MHz clock
	initial begin
		forever #5 clk = ~clk;
	end

	// hard stop in case the block hangs
	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

	// one request beat, with random idle cycles ahead of it
	task automatic issue(input req_t op, input logic [IDX_W-1:0] idx, input logic join_sel);
		while ($urandom_range(0, 99) < gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start       <= 1'b1;
		req_type    <= op;
		slot_index  <= idx;
		join_choice <= join_sel;
		do @(posedge clk); while (busy);
		issued++;
	endtask

	// stimulus and verdict
	initial begin
		req_t             op;
		logic [IDX_W-1:0] idx;
		int               roll;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: one slot through its lifecycle and the error paths
		gap_pct = 9;
		issue(REQ_DETECT, 8'hFF, 1'b0);
		issue(REQ_SERVE, 8'd0, 1'b1);
		issue(REQ_SERVE, 8'd0, 1'b0);
		issue(REQ_DECIDE, 8'd0, 1'b1);
		issue(REQ_DECIDE, 8'd0, 1'b0);
		issue(REQ_EXPIRE, 8'd0, 1'b0);
		issue(REQ_SERVE, 8'hFF, 1'b1);
		issue(REQ_DECIDE, SLOTS[IDX_W-1:0], 1'b1);
		issue(REQ_EXPIRE, SLOTS[IDX_W-1:0], 1'b0);
		// fill the table, reuse the decided slot, then overflow
		for (int i = 1; i < SLOTS; i++)
			issue(REQ_DETECT, IDX_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		issue(REQ_DETECT, 8'd0, 1'b0);
		issue(REQ_DETECT, 8'd0, 1'b1);
		// free one slot by leave and two by expire, then reclaim the lowest
		issue(REQ_DECIDE, 8'd1, 1'b0);
		issue(REQ_EXPIRE, 8'd2, 1'b1);
		issue(REQ_EXPIRE, SLOTS[IDX_W-1:0] - 8'd1, 1'b0);
		issue(REQ_DETECT, 8'd0, 1'b0);
		issue(REQ_SERVE, 8'd1, 1'b0);

		// random: sender pacing 9 %, then 58 %, then back to back
		for (int phase = 0; phase < 3; phase++) begin
			gap_pct = (phase == 0) ? 9 : (phase == 1) ? 58 : 0;
			for (int n = 0; n < PHASE_REQS; n++) begin
				roll = $urandom_range(0, 99);
				op = (roll < 30) ? REQ_DETECT : (roll < 50) ? REQ_SERVE :
					(roll < 75) ? REQ_DECIDE : REQ_EXPIRE;
				// mostly valid slots, some out of range across all index bits
				if ($urandom_range(0, 9) == 0)
					idx = IDX_W'($urandom_range(SLOTS, 255));
				else
					idx = IDX_W'($urandom_range(0, SLOTS - 1));
				issue(op, idx, 1'($urandom_range(0, 1)));
			end
		end
		start <= 1'b0;

		// drain, then give the block time to show any stray beat
		do @(posedge clk); while (outstanding != 0);
		repeat (SLOTS + 4) @(posedge clk);

		$display("covered %0d requests over three pacing phases, %0d results checked",
			issued, results_checked);
		$display("%0d error replies, %0d of them detects on a full table",
			error_replies, full_replies);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
